>>> hw/rtl/wlrp_pkg.sv
// shared types and constants of the word-list record parser
package wlrp_pkg;

	localparam int HEADER_BYTES_DEF = 32;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

	localparam logic [31:0] MAGIC_RST   = 32'd0;
	localparam logic [15:0] VERSION_RST = 16'd1;
	localparam logic [7:0]  MAX_LEN_RST = 8'd48;

	// status codes
	localparam logic [1:0] ST_PARSING  = 2'd0;
	localparam logic [1:0] ST_LOADED   = 2'd1;
	localparam logic [1:0] ST_CORRUPT  = 2'd2;
	localparam logic [1:0] ST_MISMATCH = 2'd3;

	typedef struct packed {
		logic [31:0] expected_magic;
		logic [15:0] expected_version;
		logic [7:0]  max_word_len;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        char_valid;
		logic [7:0]  char_byte;
		logic        entry_done;
		logic [31:0] entry_index;
		logic [7:0]  word_length;
		logic [31:0] frequency;
		logic [7:0]  entry_flags;
		logic [31:0] max_frequency;
		logic        header_done;
		logic [15:0] header_flags;
		logic [31:0] record_total;
	} out_item_t;

endpackage

>>> hw/rtl/wlrp_cfg.sv
// configuration registers of the word-list record parser
module wlrp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wlrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wlrp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output wlrp_pkg::cfg_t                 cfg
);
	import wlrp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_magic   <= MAGIC_RST;
			cfg_q.expected_version <= VERSION_RST;
			cfg_q.max_word_len     <= MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAGIC:   cfg_q.expected_magic   <= cfg_wdata;
				CFG_VERSION: cfg_q.expected_version <= cfg_wdata[15:0];
				CFG_MAX_LEN: cfg_q.max_word_len     <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/wlrp_parse.sv
// parse state and per-byte step logic of the word-list record parser
module wlrp_parse #(
	parameter int HEADER_BYTES = wlrp_pkg::HEADER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wlrp_pkg::cfg_t      cfg,
	input  wlrp_pkg::in_item_t  item,
	input  logic                step,
	output wlrp_pkg::out_item_t res
);
	import wlrp_pkg::*;

	localparam int HPW = $clog2(HEADER_BYTES);
	localparam logic [HPW-1:0] HDR_LAST = HPW'(HEADER_BYTES - 1);

	typedef enum logic [2:0] {
		PH_HEADER, PH_LEN, PH_WORD, PH_FREQ, PH_FLAG, PH_DONE, PH_HALT
	} phase_t;

	phase_t         phase_q, phase_n, phase_b;
	logic [HPW-1:0] hpos_q, hpos_n, hpos_b;
	logic [1:0]     fpos_q, fpos_n, fpos_b;
	logic [7:0]     left_q, left_n, left_b;
	logic [7:0]     len_q, len_n, len_b;
	logic [31:0]    freq_q, freq_n, freq_b;
	logic [31:0]    magic_q, magic_n, magic_b;
	logic [15:0]    ver_q, ver_n, ver_b;
	logic [15:0]    hflags_q, hflags_n, hflags_b;
	logic [31:0]    count_q, count_n, count_b;
	logic [31:0]    seen_q, seen_n, seen_b;
	logic [31:0]    maxf_q, maxf_n, maxf_b;
	logic [1:0]     status_q, status_n, status_b;
	logic [7:0]     b;
	logic           hdr_acc;

	always_comb begin
		b = item.data_byte;
		// a first-byte mark restarts parsing before this byte is taken
		if (item.first_byte) begin
			phase_b  = PH_HEADER;
			hpos_b   = '0;
			fpos_b   = '0;
			left_b   = '0;
			len_b    = '0;
			freq_b   = '0;
			magic_b  = '0;
			ver_b    = '0;
			hflags_b = '0;
			count_b  = '0;
			seen_b   = '0;
			maxf_b   = '0;
			status_b = ST_PARSING;
		end else begin
			phase_b  = phase_q;
			hpos_b   = hpos_q;
			fpos_b   = fpos_q;
			left_b   = left_q;
			len_b    = len_q;
			freq_b   = freq_q;
			magic_b  = magic_q;
			ver_b    = ver_q;
			hflags_b = hflags_q;
			count_b  = count_q;
			seen_b   = seen_q;
			maxf_b   = maxf_q;
			status_b = status_q;
		end

		phase_n  = phase_b;
		hpos_n   = hpos_b;
		fpos_n   = fpos_b;
		left_n   = left_b;
		len_n    = len_b;
		freq_n   = freq_b;
		magic_n  = magic_b;
		ver_n    = ver_b;
		hflags_n = hflags_b;
		count_n  = count_b;
		seen_n   = seen_b;
		maxf_n   = maxf_b;
		status_n = status_b;
		res      = '0;

		unique case (phase_b)
			PH_HEADER: begin
				if (hpos_b < HPW'(4)) begin
					case (hpos_b[1:0])
						2'd0: magic_n[7:0]   = magic_b[7:0]   | b;
						2'd1: magic_n[15:8]  = magic_b[15:8]  | b;
						2'd2: magic_n[23:16] = magic_b[23:16] | b;
						default: magic_n[31:24] = magic_b[31:24] | b;
					endcase
				end else if (hpos_b < HPW'(6)) begin
					if (hpos_b[0]) ver_n[15:8] = ver_b[15:8] | b;
					else ver_n[7:0] = ver_b[7:0] | b;
				end else if (hpos_b < HPW'(8)) begin
					if (hpos_b[0]) hflags_n[15:8] = hflags_b[15:8] | b;
					else hflags_n[7:0] = hflags_b[7:0] | b;
				end else if (hpos_b < HPW'(12)) begin
					case (hpos_b[1:0])
						2'd0: count_n[7:0]   = count_b[7:0]   | b;
						2'd1: count_n[15:8]  = count_b[15:8]  | b;
						2'd2: count_n[23:16] = count_b[23:16] | b;
						default: count_n[31:24] = count_b[31:24] | b;
					endcase
				end
				if (hpos_b == HDR_LAST) begin
					// magic is checked ahead of version
					if (magic_n != cfg.expected_magic) begin
						status_n = ST_CORRUPT;
						phase_n  = PH_HALT;
					end else if (ver_n != cfg.expected_version) begin
						status_n = ST_MISMATCH;
						phase_n  = PH_HALT;
					end else begin
						res.header_done = 1'b1;
						if (count_n == 32'd0) begin
							status_n = ST_LOADED;
							phase_n  = PH_DONE;
						end else begin
							phase_n = PH_LEN;
						end
					end
				end else begin
					hpos_n = hpos_b + HPW'(1);
				end
			end
			PH_LEN: begin
				if (b > cfg.max_word_len) begin
					status_n = ST_CORRUPT;
					phase_n  = PH_DONE;
				end else begin
					len_n   = b;
					left_n  = b;
					freq_n  = '0;
					fpos_n  = '0;
					phase_n = (b != 8'd0) ? PH_WORD : PH_FREQ;
				end
			end
			PH_WORD: begin
				res.char_valid = 1'b1;
				res.char_byte  = b;
				left_n = left_b - 8'd1;
				if (left_n == 8'd0) phase_n = PH_FREQ;
			end
			PH_FREQ: begin
				case (fpos_b)
					2'd0: freq_n[7:0]   = freq_b[7:0]   | b;
					2'd1: freq_n[15:8]  = freq_b[15:8]  | b;
					2'd2: freq_n[23:16] = freq_b[23:16] | b;
					default: freq_n[31:24] = freq_b[31:24] | b;
				endcase
				if (fpos_b == 2'd3) begin
					fpos_n  = '0;
					phase_n = PH_FLAG;
				end else begin
					fpos_n = fpos_b + 2'd1;
				end
			end
			PH_FLAG: begin
				res.entry_done  = 1'b1;
				res.entry_index = seen_b;
				res.word_length = len_b;
				res.frequency   = freq_b;
				res.entry_flags = b;
				if (freq_b > maxf_b) maxf_n = freq_b;
				seen_n = seen_b + 32'd1;
				if (seen_n == count_b) begin
					status_n = ST_LOADED;
					phase_n  = PH_DONE;
				end else begin
					phase_n = PH_LEN;
				end
			end
			default: begin
			end
		endcase

		// stream ended before the parse finished
		if (item.last_byte && status_n == ST_PARSING) begin
			status_n = ST_CORRUPT;
			if (phase_n == PH_LEN || phase_n == PH_WORD || phase_n == PH_FREQ ||
					phase_n == PH_FLAG || phase_n == PH_DONE) begin
				phase_n = PH_DONE;
			end else begin
				phase_n = PH_HALT;
			end
		end

		hdr_acc = (phase_n == PH_LEN || phase_n == PH_WORD || phase_n == PH_FREQ ||
				phase_n == PH_FLAG || phase_n == PH_DONE);
		res.status        = status_n;
		res.max_frequency = maxf_n;
		res.header_flags  = hdr_acc ? hflags_n : 16'd0;
		res.record_total  = hdr_acc ? count_n : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hpos_q   <= '0;
			fpos_q   <= '0;
			left_q   <= '0;
			len_q    <= '0;
			freq_q   <= '0;
			magic_q  <= '0;
			ver_q    <= '0;
			hflags_q <= '0;
			count_q  <= '0;
			seen_q   <= '0;
			maxf_q   <= '0;
			status_q <= ST_PARSING;
		end else if (step) begin
			phase_q  <= phase_n;
			hpos_q   <= hpos_n;
			fpos_q   <= fpos_n;
			left_q   <= left_n;
			len_q    <= len_n;
			freq_q   <= freq_n;
			magic_q  <= magic_n;
			ver_q    <= ver_n;
			hflags_q <= hflags_n;
			count_q  <= count_n;
			seen_q   <= seen_n;
			maxf_q   <= maxf_n;
			status_q <= status_n;
		end
	end

`ifndef SYNTHESIS
	a_header_fits: assert property (@(posedge clk) disable iff (!arst_n)
		hpos_q <= HDR_LAST)
		else $error("header position ran past the header");

	a_done_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE || phase_q == PH_HALT) |-> status_q != ST_PARSING)
		else $error("finished parse without a final status");

	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WORD |-> left_q != 8'd0 && left_q <= len_q)
		else $error("word byte count out of range");
`endif

endmodule

>>> hw/rtl/word_list_record_parser.sv
// word-list record parser top level: input register, parse step, result register
// a byte accepted into the input register passes the parse step into the result register, which drives out_valid
// throughput: one byte per cycle while out_stall is low; the parse step between the two registers sets it
// in_stall rises only when the input register is full and the result register is stalled
// reset: arst_n clears parse state to header parsing, restores the configuration defaults
// and empties both pipeline registers; no clearing pass is needed
module word_list_record_parser #(
	parameter int HEADER_BYTES = wlrp_pkg::HEADER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  wlrp_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output wlrp_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [wlrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wlrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import wlrp_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t res_s2;
	logic      valid_s2;
	logic      take;
	logic      adv;
	logic      in_xfer;

	wlrp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	wlrp_parse #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (adv),
		.res    (res)
	);

	// result register can take a new item when empty or being drained
	assign take     = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && take;
	assign in_stall = valid_s1 && !take;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) valid_s2 <= 1'b1;
			else if (!out_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) item_s1 <= in_data;
		if (adv) res_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with room in the pipeline");

	a_char_or_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.char_valid && out_data.entry_done))
		else $error("character and record end on the same byte");

	// an accepted header can still end corrupt when the stream stops on it
	a_header_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.header_done |-> out_data.status != ST_MISMATCH)
		else $error("header accepted with a version mismatch");

	a_max_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.entry_done |-> out_data.frequency <= out_data.max_frequency)
		else $error("record frequency above running maximum");
`endif

endmodule

>>> verif/word_list_record_parser_checker.sv
// checker of the word-list record parser: watches both channels, predicts each result, compares
`timescale 1ns / 100ps
module word_list_record_parser_checker #(
	parameter int HEADER_BYTES = wlrp_pkg::HEADER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  wlrp_pkg::in_item_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  wlrp_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [wlrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wlrp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              fail_count,
	output int                              pending
);
	import wlrp_pkg::*;

	typedef enum logic [2:0] {
		P_HEADER, P_LEN, P_WORD, P_FREQ, P_FLAG, P_DONE, P_HALT
	} parse_phase_t;

	// configuration copy
	logic [31:0] exp_magic;
	logic [15:0] exp_version;
	logic [7:0]  max_len;

	// parse state copy
	logic [5:0]   hdr_pos;
	parse_phase_t phase;
	logic [1:0]   byte_pos;
	logic [7:0]   word_left;
	logic [7:0]   cur_len;
	logic [31:0]  freq_acc;
	logic [31:0]  magic_acc;
	logic [15:0]  ver_acc;
	logic [15:0]  hdr_flags;
	logic [31:0]  rec_count;
	logic [31:0]  rec_seen;
	logic [31:0]  max_freq;
	logic [1:0]   status;

	out_item_t results_due[$];
	int err_total = 0;

	function automatic void restart_parse();
		hdr_pos = '0;
		phase = P_HEADER;
		byte_pos = '0;
		word_left = '0;
		cur_len = '0;
		freq_acc = '0;
		magic_acc = '0;
		ver_acc = '0;
		hdr_flags = '0;
		rec_count = '0;
		rec_seen = '0;
		max_freq = '0;
		status = ST_PARSING;
	endfunction

	function automatic out_item_t parse_byte(in_item_t it);
		out_item_t r;
		logic [7:0] b;
		int p;
		logic accepted;
		r = '0;
		b = it.data_byte;
		if (it.first_byte)
			restart_parse();
		case (phase)
		P_HEADER: begin
			p = int'(hdr_pos);
			if (p < 4)
				magic_acc |= 32'(b) << (8 * p);
			else if (p < 6)
				ver_acc |= 16'(b) << (8 * (p - 4));
			else if (p < 8)
				hdr_flags |= 16'(b) << (8 * (p - 6));
			else if (p < 12)
				rec_count |= 32'(b) << (8 * (p - 8));
			if (p + 1 >= HEADER_BYTES) begin
				// magic is judged before version
				if (magic_acc != exp_magic) begin
					status = ST_CORRUPT;
					phase = P_HALT;
				end else if (ver_acc != exp_version) begin
					status = ST_MISMATCH;
					phase = P_HALT;
				end else begin
					r.header_done = 1'b1;
					if (rec_count == 0) begin
						status = ST_LOADED;
						phase = P_DONE;
					end else begin
						phase = P_LEN;
					end
				end
			end else begin
				hdr_pos = 6'(p + 1);
			end
		end
		P_LEN: begin
			if (b > max_len) begin
				status = ST_CORRUPT;
				phase = P_DONE;
			end else begin
				cur_len = b;
				word_left = b;
				freq_acc = '0;
				byte_pos = '0;
				phase = (b != 0) ? P_WORD : P_FREQ;
			end
		end
		P_WORD: begin
			r.char_valid = 1'b1;
			r.char_byte = b;
			word_left = word_left - 8'd1;
			if (word_left == 0)
				phase = P_FREQ;
		end
		P_FREQ: begin
			freq_acc |= 32'(b) << (8 * byte_pos);
			if (byte_pos == 2'd3) begin
				byte_pos = '0;
				phase = P_FLAG;
			end else begin
				byte_pos = byte_pos + 2'd1;
			end
		end
		P_FLAG: begin
			r.entry_done = 1'b1;
			r.entry_index = rec_seen;
			r.word_length = cur_len;
			r.frequency = freq_acc;
			r.entry_flags = b;
			if (freq_acc > max_freq)
				max_freq = freq_acc;
			rec_seen = rec_seen + 32'd1;
			if (rec_seen == rec_count) begin
				status = ST_LOADED;
				phase = P_DONE;
			end else begin
				phase = P_LEN;
			end
		end
		default: ;
		endcase

		accepted = (phase >= P_LEN && phase <= P_DONE);
		// stream ran out while still parsing
		if (it.last_byte && status == ST_PARSING) begin
			status = ST_CORRUPT;
			phase = accepted ? P_DONE : P_HALT;
		end

		r.status = status;
		r.max_frequency = max_freq;
		if (accepted) begin
			r.header_flags = hdr_flags;
			r.record_total = rec_count;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			err_total++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			exp_magic = MAGIC_RST;
			exp_version = VERSION_RST;
			max_len = MAX_LEN_RST;
			restart_parse();
			results_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				CFG_MAGIC:   exp_magic = cfg_wdata;
				CFG_VERSION: exp_version = cfg_wdata[15:0];
				CFG_MAX_LEN: max_len = cfg_wdata[7:0];
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					err_total++;
					$display("%0t: result transfer with nothing expected, got %h",
						$time, out_data);
				end else begin
					want = results_due.pop_front();
					check_field("status", 32'(want.status), 32'(out_data.status));
					check_field("char_valid", 32'(want.char_valid), 32'(out_data.char_valid));
					check_field("char_byte", 32'(want.char_byte), 32'(out_data.char_byte));
					check_field("entry_done", 32'(want.entry_done), 32'(out_data.entry_done));
					check_field("entry_index", want.entry_index, out_data.entry_index);
					check_field("word_length", 32'(want.word_length),
						32'(out_data.word_length));
					check_field("frequency", want.frequency, out_data.frequency);
					check_field("entry_flags", 32'(want.entry_flags),
						32'(out_data.entry_flags));
					check_field("max_frequency", want.max_frequency, out_data.max_frequency);
					check_field("header_done", 32'(want.header_done),
						32'(out_data.header_done));
					check_field("header_flags", 32'(want.header_flags),
						32'(out_data.header_flags));
					check_field("record_total", want.record_total, out_data.record_total);
				end
			end
			if (in_valid && !in_stall)
				results_due.insert(results_due.size(), parse_byte(in_data));
		end
		fail_count <= err_total;
		pending <= results_due.size();
	end

endmodule

>>> verif/word_list_record_parser_tb.sv
// testbench top of the word-list record parser: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module word_list_record_parser_tb;
	import wlrp_pkg::*;

	localparam int HDR_BYTES = HEADER_BYTES_DEF;
	localparam int LIMIT = 600000;
	localparam int TARGET_BYTES = 1000;
	localparam int PHASES = 5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MAGIC;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int fail_count;
	int pending;

	int cycles = 0;
	int bytes_sent = 0;
	int send_calm = 0;
	int drain_calm = 0;

	// configuration currently loaded in the block
	logic [31:0] cur_magic = MAGIC_RST;
	logic [15:0] cur_version = VERSION_RST;
	logic [7:0]  cur_max_len = MAX_LEN_RST;

	logic [7:0] image[$];

	word_list_record_parser #(.HEADER_BYTES(HDR_BYTES)) i_dut (.*);

	word_list_record_parser_checker #(.HEADER_BYTES(HDR_BYTES)) i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("word_list_record_parser_tb: done, errors");
			$finish;
		end
	end

	// random wait per transfer, with occasional stretches of none
	task automatic draw_gap(inout int calm, output int gap);
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 31) == 0)
				calm = $urandom_range(16, 64);
			gap = $urandom_range(0, 5);
		end
	endtask

	initial begin : drain
		int hold;
		forever begin
			draw_gap(drain_calm, hold);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
		int gap;
		draw_gap(send_calm, gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: d, first_byte: f, last_byte: l};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// all results in and the block quiet
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic [31:0] m, input logic [15:0] v,
			input logic [7:0] len);
		cur_magic = m;
		cur_version = v;
		cur_max_len = len;
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAGIC;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_index <= CFG_VERSION;
		cfg_wdata <= 32'(v);
		@(posedge clk);
		cfg_index <= CFG_MAX_LEN;
		cfg_wdata <= 32'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// append one byte to the image under construction
	function automatic void add_byte(input logic [7:0] v);
		image.insert(image.size(), v);
	endfunction

	task automatic put_header(input logic [31:0] m, input logic [15:0] v,
			input logic [31:0] count);
		logic [15:0] flags;
		flags = 16'($urandom);
		for (int i = 0; i < 4; i++) add_byte(m[8*i +: 8]);
		for (int i = 0; i < 2; i++) add_byte(v[8*i +: 8]);
		for (int i = 0; i < 2; i++) add_byte(flags[8*i +: 8]);
		for (int i = 0; i < 4; i++) add_byte(count[8*i +: 8]);
		for (int i = 12; i < HDR_BYTES; i++) add_byte(8'($urandom));
	endtask

	task automatic put_record(input int len, input logic [31:0] freq);
		add_byte(8'(len));
		for (int i = 0; i < len; i++) add_byte(8'($urandom));
		for (int i = 0; i < 4; i++) add_byte(freq[8*i +: 8]);
		add_byte(8'($urandom));
	endtask

	function automatic int pick_len();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return int'(cur_max_len);
		if (pick == 1)
			return $urandom_range(0, int'(cur_max_len));
		return $urandom_range(0, (cur_max_len < 6) ? int'(cur_max_len) : 6);
	endfunction

	function automatic logic [31:0] pick_freq();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 32'd0;
		if (pick == 1)
			return 32'hFFFF_FFFF;
		return 32'($urandom);
	endfunction

	task automatic play_image(input bit mark_first, input bit mark_last, input int stop);
		for (int i = 0; i <= stop; i++)
			send_byte(image[i], mark_first && i == 0, mark_last && i == stop);
		bytes_sent += stop + 1;
		image.delete();
	endtask

	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
	endtask

	task automatic random_image();
		int kind;
		int n;
		int stop;
		bit mark_last;
		logic [31:0] m;
		logic [31:0] count;
		logic [15:0] v;
		kind = $urandom_range(0, 17);
		n = $urandom_range(1, 5);
		m = cur_magic;
		v = cur_version;
		count = n;
		mark_last = 1'b1;
		case (kind)
		0: m = cur_magic ^ (32'd1 << $urandom_range(0, 31));
		1: v = cur_version ^ (16'd1 << $urandom_range(0, 15));
		2: count = 0;
		3: count = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'(n + $urandom_range(1, 3));
		4: count = n + 1;
		9: count = (n > 1) ? 32'($urandom_range(1, n - 1)) : 32'd1;
		default: ;
		endcase
		if (kind == 10) begin
			send_noise($urandom_range(1, 8));
			return;
		end
		put_header(m, v, count);
		if (kind > 2) begin
			for (int i = 0; i < n; i++) put_record(pick_len(), pick_freq());
		end
		// overlong word after some good records
		if (kind == 4 && cur_max_len != 8'hFF) begin
			add_byte(8'($urandom_range(int'(cur_max_len) + 1, 255)));
			repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
		end
		// bytes after a finished parse
		if (kind == 8)
			repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
		stop = image.size() - 1;
		if (kind == 5) begin
			stop = $urandom_range(0, HDR_BYTES - 2);
		end else if (kind == 6) begin
			stop = $urandom_range(HDR_BYTES, image.size() - 2);
		end else if (kind == 7) begin
			stop = $urandom_range(0, image.size() - 1);
			mark_last = 1'b0;
		end
		play_image(1'b1, mark_last, stop);
	endtask

	initial begin : stimulus
		int goal;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// well-formed image with no start mark after reset, word lengths zero and at the limit
		put_header(cur_magic, cur_version, 32'd2);
		put_record(0, 32'hFFFF_FFFF);
		put_record(int'(cur_max_len), 32'd0);
		play_image(1'b0, 1'b1, image.size() - 1);
		// zero entry count
		put_header(cur_magic, cur_version, 32'd0);
		play_image(1'b1, 1'b1, image.size() - 1);
		// bad magic together with bad version
		put_header(~cur_magic, ~cur_version, 32'd1);
		play_image(1'b1, 1'b1, image.size() - 1);
		// bad version only
		put_header(cur_magic, ~cur_version, 32'd1);
		play_image(1'b1, 1'b1, image.size() - 1);
		// overlong word after one good record, then ignored bytes
		put_header(cur_magic, cur_version, 32'd3);
		put_record(5, 32'h0000_0100);
		add_byte(cur_max_len + 8'd1);
		repeat (3) add_byte(8'($urandom));
		play_image(1'b1, 1'b1, image.size() - 1);
		// stream ends inside the header
		put_header(cur_magic, cur_version, 32'd1);
		play_image(1'b1, 1'b1, 10);
		// stream ends inside a word, huge entry count, then ignored bytes
		put_header(cur_magic, cur_version, 32'hFFFF_FFFF);
		put_record(3, 32'h1234_5678);
		put_record(2, 32'h0000_0001);
		play_image(1'b1, 1'b1, image.size() - 7);
		repeat (4) send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
		// new image mark in the middle of an image
		put_header(cur_magic, cur_version, 32'd2);
		put_record(4, 32'h00FF_00FF);
		put_record(1, 32'h8000_0000);
		play_image(1'b1, 1'b0, HDR_BYTES + 3);
		put_header(cur_magic, cur_version, 32'd1);
		put_record(2, 32'h7FFF_FFFF);
		play_image(1'b1, 1'b1, image.size() - 1);

		bytes_sent = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case (ph)
			0: write_config(32'($urandom), 16'($urandom), 8'($urandom_range(8, 64)));
			1: write_config(32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
			2: write_config(32'd0, 16'd0, 8'd0);
			3: write_config(32'($urandom), 16'd1, 8'($urandom_range(1, 20)));
			default: write_config(32'($urandom), 16'($urandom), 8'($urandom));
			endcase
			goal = (ph + 1) * TARGET_BYTES / PHASES;
			while (bytes_sent < goal) random_image();
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("word_list_record_parser_tb: done, clean");
		else
			$display("word_list_record_parser_tb: done, errors");
		$finish;
	end

endmodule
